### rtl/avsei_pkg.sv
// Shared types and constants for the AVCC to start-code converter with SEI tagging.
// Used by the parser, the output queue and the top level; no dependencies.
package avsei_pkg;

  localparam int NAL_LENGTH_BITS_DEFAULT = 32;

  // Parser phases.
  localparam logic [2:0] PH_LEN  = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_SIZE = 3'd3;
  localparam logic [2:0] PH_UUID = 3'd4;
  localparam logic [2:0] PH_PAY  = 3'd5;
  localparam logic [2:0] PH_PASS = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LENGTH_FIELD_BYTES = 2'd0;
  localparam logic [1:0] CFG_UUID_UPPER         = 2'd1;
  localparam logic [1:0] CFG_UUID_LOWER         = 2'd2;

  localparam logic [2:0]  LENGTH_FIELD_BYTES_RESET = 3'd4;
  localparam logic [31:0] START_CODE               = 32'h0000_0001;
  localparam logic [4:0]  NAL_TYPE_SEI             = 5'h06;
  localparam logic [7:0]  SEI_USER_DATA            = 8'h05;
  localparam logic [7:0]  SEI_SIZE_EXTEND          = 8'hff;

  // Pending result queue.
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // One queued record: either a whole start code or one passed NAL byte.
  typedef struct packed {
    logic       sc;
    logic [7:0] data;
    logic       sei;
  } rec_t;

endpackage

### rtl/avsei_parser.sv
// Byte parser: length prefix collection, NAL countdown and user-data SEI UUID match.
// Depends on avsei_pkg; produces at most one queue record per accepted byte.
module avsei_parser
  import avsei_pkg::*;
#(
  parameter int NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        tag_last,
  input  logic [2:0]  length_field_bytes,
  input  logic [63:0] uuid_upper,
  input  logic [63:0] uuid_lower,
  output logic        rec_valid,
  output rec_t        rec
);

  logic [2:0]                 phase, phase_next;
  logic [1:0]                 seen, seen_next;
  logic [31:0]                accum, accum_next, accum_shift;
  logic [NAL_LENGTH_BITS-1:0] left, left_next, left_dec, len;
  logic [3:0]                 pos, pos_next;
  logic                       match, match_next;

  logic [2:0]  psize;
  logic        complete;
  logic        sat;
  logic [63:0] uuid_word;
  logic [7:0]  uuid_byte;
  logic        match_step;

  always_comb begin
    psize = (length_field_bytes >= 3'd2 && length_field_bytes <= 3'd4) ?
            length_field_bytes : 3'd1;
    accum_shift = {accum[23:0], data_byte};
    complete    = ((seen + 2'd1) == 2'd0) || ({1'b0, seen + 2'd1} >= psize);
    sat         = (accum_shift >> NAL_LENGTH_BITS) != 32'd0;
    len         = sat ? '1 : accum_shift[NAL_LENGTH_BITS-1:0];
    left_dec    = left - 1'b1;
    uuid_word   = pos[3] ? uuid_lower : uuid_upper;
    uuid_byte   = 8'(uuid_word >> {~pos[2:0], 3'b000});
    match_step  = match && (data_byte == uuid_byte);
  end

  always_comb begin
    phase_next = phase;
    seen_next  = seen;
    accum_next = accum;
    left_next  = left;
    pos_next   = pos;
    match_next = match;
    rec_valid  = 1'b0;
    rec.sc     = 1'b0;
    rec.data   = data_byte;
    rec.sei    = 1'b0;

    if (phase == PH_LEN || left == '0) begin
      seen_next  = seen + 2'd1;
      accum_next = accum_shift;
      if (complete) begin
        rec_valid  = 1'b1;
        rec.sc     = 1'b1;
        seen_next  = 2'd0;
        accum_next = 32'd0;
        left_next  = len;
        phase_next = (len != '0) ? PH_HDR : PH_LEN;
      end
    end else begin
      rec_valid = 1'b1;
      rec.sei   = (phase == PH_PAY) && (left_dec != '0);
      case (phase)
        PH_HDR:  phase_next = (data_byte[4:0] == NAL_TYPE_SEI) ? PH_TYPE : PH_PASS;
        PH_TYPE: phase_next = (data_byte == SEI_USER_DATA) ? PH_SIZE : PH_PASS;
        PH_SIZE: begin
          if (data_byte != SEI_SIZE_EXTEND) begin
            phase_next = PH_UUID;
            pos_next   = 4'd0;
            match_next = 1'b1;
          end
        end
        PH_UUID: begin
          match_next = match_step;
          pos_next   = pos + 4'd1;
          if (pos == 4'd15) begin
            phase_next = match_step ? PH_PAY : PH_PASS;
          end
        end
        PH_PAY:  phase_next = PH_PAY;
        default: phase_next = PH_PASS;
      endcase
      left_next = left_dec;
      if (left_dec == '0) begin
        phase_next = PH_LEN;
        pos_next   = 4'd0;
        match_next = 1'b1;
      end
    end

    // The final byte of a tag abandons whatever prefix or NAL is in flight.
    if (tag_last) begin
      phase_next = PH_LEN;
      seen_next  = 2'd0;
      accum_next = 32'd0;
      left_next  = '0;
      pos_next   = 4'd0;
      match_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN;
      seen  <= 2'd0;
      accum <= 32'd0;
      left  <= '0;
      pos   <= 4'd0;
      match <= 1'b1;
    end else if (accept) begin
      phase <= phase_next;
      seen  <= seen_next;
      accum <= accum_next;
      left  <= left_next;
      pos   <= pos_next;
      match <= match_next;
    end
  end

  a_nal_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase != PH_LEN |-> left != '0)
    else $error("parser in a NAL phase with no bytes left");

  a_tag_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && tag_last |=> phase == PH_LEN && seen == 2'd0 && left == '0)
    else $error("parser not cleared after the last byte of a tag");

  a_uuid_pos_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_UUID |-> pos == 4'd0)
    else $error("UUID position moved outside the UUID phase");

endmodule

### rtl/avsei_outq.sv
// Pending result queue: holds parser records and expands start codes into four bytes.
// Depends on avsei_pkg for the record type and queue depth.
module avsei_outq
  import avsei_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rec_t       push_rec,
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_start_code,
  output logic       sei_payload,
  output logic       last_of_run
);

  rec_t                 store [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic [1:0]           beat;
  rec_t                 head;
  logic                 xfer, pop;

  always_comb begin
    head          = store[rd_ptr];
    full          = (count == QCNT_BITS'(QDEPTH));
    out_valid     = (count != '0);
    is_start_code = head.sc;
    sei_payload   = head.sei && !head.sc;
    out_byte      = head.sc ? 8'(START_CODE >> {~beat, 3'b000}) : head.data;
    last_of_run   = !head.sc || (beat == 2'd3);
    xfer          = out_valid && !out_stall;
    pop           = xfer && last_of_run;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      beat   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
      if (pop) begin
        beat <= 2'd0;
      end else if (xfer) begin
        beat <= beat + 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("record pushed into a full queue");

  a_beat_only_sc: assert property (@(posedge clk) disable iff (rst)
    beat != 2'd0 |-> out_valid && head.sc)
    else $error("start code beat active without a start code at the head");

  a_pop_resets_beat: assert property (@(posedge clk) disable iff (rst)
    pop |=> beat == 2'd0)
    else $error("beat counter not cleared after a record left the queue");

endmodule

### rtl/avcc_to_annexb_sei_extract_core.sv
// Top level of the AVCC to start-code converter with user-data SEI tagging.
// Depends on avsei_pkg, avsei_parser and avsei_outq.
//
// Input channel (in_valid, in_stall, data_byte, tag_last) carries the NAL region
// of one video tag, one byte per transfer, with tag_last on its final byte.
// Output channel (out_valid, out_stall, ...) carries the framed stream, one byte
// per transfer: a completed length prefix becomes the four bytes 00 00 00 01
// (is_start_code set, last_of_run on the 01), every NAL byte passes through once
// (last_of_run set), and bytes of a matched user-data SEI payload carry sei_payload.
// Prefix bytes that do not complete a prefix produce nothing.
// An input byte is parsed in the cycle it is taken; its results are registered in the
// queue and offered behind any earlier records. The parser takes one byte per cycle
// while in_stall is low, and the output side sends one byte per cycle while out_stall is low.
// A four-record queue sits between them and in_stall rises only when that queue is full.
// While out_stall is high the offered byte and flags hold.
// Reset empties the queue, returns the parser to the length phase and sets
// length_field_bytes to 4 and both UUID halves to zero. Configuration writes on
// cfg_valid/cfg_ready are always taken and belong in idle periods.
module avcc_to_annexb_sei_extract_core
  import avsei_pkg::*;
#(
  parameter int NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        tag_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_start_code,
  output logic        sei_payload,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [2:0]  length_field_bytes;
  logic [63:0] uuid_upper;
  logic [63:0] uuid_lower;
  logic        accept;
  logic        rec_valid;
  rec_t        rec;
  logic        full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_field_bytes <= LENGTH_FIELD_BYTES_RESET;
      uuid_upper         <= 64'd0;
      uuid_lower         <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LENGTH_FIELD_BYTES: length_field_bytes <= cfg_data[2:0];
        CFG_UUID_UPPER:         uuid_upper         <= cfg_data;
        CFG_UUID_LOWER:         uuid_lower         <= cfg_data;
        default: ;
      endcase
    end
  end

  avsei_parser #(
    .NAL_LENGTH_BITS(NAL_LENGTH_BITS)
  ) u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .data_byte         (data_byte),
    .tag_last          (tag_last),
    .length_field_bytes(length_field_bytes),
    .uuid_upper        (uuid_upper),
    .uuid_lower        (uuid_lower),
    .rec_valid         (rec_valid),
    .rec               (rec)
  );

  avsei_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (accept && rec_valid),
    .push_rec     (rec),
    .full         (full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .is_start_code(is_start_code),
    .sei_payload  (sei_payload),
    .last_of_run  (last_of_run)
  );

endmodule
